FILE: design/mlr_pkg.sv
package mlr_pkg;

	typedef enum logic {
		ST_IDLE,
		ST_RUN
	} state_t;

	// Octant of the segment after the endpoints are ordered left to right.
	typedef enum logic [1:0] {
		OCT_SHALLOW_UP,
		OCT_SHALLOW_DOWN,
		OCT_STEEP_UP,
		OCT_STEEP_DOWN
	} octant_t;

	typedef struct packed {
		logic load;
		logic step;
	} cmd_t;

	typedef struct packed {
		logic last;
	} sts_t;

endpackage

FILE: design/mlr_seg_if.sv
interface mlr_seg_if #(
	parameter int COORD_BITS = 6
) ();
	logic                  valid;
	logic                  ready;
	logic [COORD_BITS-1:0] start_x;
	logic [COORD_BITS-1:0] start_y;
	logic [COORD_BITS-1:0] end_x;
	logic [COORD_BITS-1:0] end_y;

	modport source (output valid, output start_x, output start_y, output end_x,
		output end_y, input ready);
	modport sink (input valid, input start_x, input start_y, input end_x,
		input end_y, output ready);
endinterface

FILE: design/mlr_pix_if.sv
interface mlr_pix_if #(
	parameter int COORD_BITS = 6
) ();
	logic                  valid;
	logic                  ready;
	logic [COORD_BITS-1:0] pixel_x;
	logic [COORD_BITS-1:0] pixel_y;
	logic                  last_pixel;

	modport source (output valid, output pixel_x, output pixel_y, output last_pixel,
		input ready);
	modport sink (input valid, input pixel_x, input pixel_y, input last_pixel,
		output ready);
endinterface

FILE: design/mlr_ctrl.sv
module mlr_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          seg_valid,
	output logic          seg_ready,
	output logic          pix_valid,
	input  logic          pix_ready,
	input  mlr_pkg::sts_t sts,
	output mlr_pkg::cmd_t cmd
);

	mlr_pkg::state_t state_q;
	mlr_pkg::state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= mlr_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		seg_ready = 1'b0;
		pix_valid = 1'b0;
		cmd       = '0;
		case (state_q)
			mlr_pkg::ST_IDLE: begin
				seg_ready = 1'b1;
				if (seg_valid) begin
					cmd.load = 1'b1;
					state_d  = mlr_pkg::ST_RUN;
				end
			end
			mlr_pkg::ST_RUN: begin
				pix_valid = 1'b1;
				if (pix_ready) begin
					if (sts.last) begin
						// The next segment loads in the cycle its predecessor's last word leaves.
						seg_ready = 1'b1;
						if (seg_valid) begin
							cmd.load = 1'b1;
						end else begin
							state_d = mlr_pkg::ST_IDLE;
						end
					end else begin
						cmd.step = 1'b1;
					end
				end
			end
			default: begin
				state_d = mlr_pkg::ST_IDLE;
			end
		endcase
	end

endmodule

FILE: design/mlr_dp.sv
module mlr_dp #(
	parameter int COORD_BITS = 6
) (
	input  logic                  clk,
	input  mlr_pkg::cmd_t         cmd,
	output mlr_pkg::sts_t         sts,
	input  logic [COORD_BITS-1:0] start_x,
	input  logic [COORD_BITS-1:0] start_y,
	input  logic [COORD_BITS-1:0] end_x,
	input  logic [COORD_BITS-1:0] end_y,
	output logic [COORD_BITS-1:0] pixel_x,
	output logic [COORD_BITS-1:0] pixel_y,
	output logic                  last_pixel
);

	localparam int DW = COORD_BITS + 4;

	logic [COORD_BITS-1:0] x_q, y_q, n_q;
	logic signed [DW-1:0]  d_q, inc_s_q, inc_d_q;
	mlr_pkg::octant_t      oct_q;

	// Set-up values for a new segment.
	logic                  swap;
	logic [COORD_BITS-1:0] x0, y0, x1, y1;
	logic signed [DW-1:0]  a, b, dy;
	logic signed [DW-1:0]  d_init, inc_s_init, inc_d_init;
	logic [COORD_BITS-1:0] n_init;
	mlr_pkg::octant_t      oct_init;

	always_comb begin
		swap = end_x < start_x;
		x0   = swap ? end_x : start_x;
		y0   = swap ? end_y : start_y;
		x1   = swap ? start_x : end_x;
		y1   = swap ? start_y : end_y;
		b    = DW'(x1) - DW'(x0);
		dy   = DW'(y1) - DW'(y0);
		a    = -dy;
		if (dy >= 0 && dy <= b) begin
			oct_init   = mlr_pkg::OCT_SHALLOW_UP;
			d_init     = DW'(2 * a + b);
			inc_s_init = DW'(2 * a);
			inc_d_init = DW'(2 * (a + b));
			n_init     = b[COORD_BITS-1:0];
		end else if (dy <= 0 && dy >= -b) begin
			oct_init   = mlr_pkg::OCT_SHALLOW_DOWN;
			d_init     = DW'(2 * a - b);
			inc_s_init = DW'(2 * a);
			inc_d_init = DW'(2 * a - 2 * b);
			n_init     = b[COORD_BITS-1:0];
		end else if (dy > b) begin
			oct_init   = mlr_pkg::OCT_STEEP_UP;
			d_init     = DW'(a + 2 * b);
			inc_s_init = DW'(2 * b);
			inc_d_init = DW'(2 * (a + b));
			n_init     = dy[COORD_BITS-1:0];
		end else begin
			oct_init   = mlr_pkg::OCT_STEEP_DOWN;
			d_init     = DW'(a - 2 * b);
			inc_s_init = DW'(-2 * b);
			inc_d_init = DW'(2 * (a - b));
			n_init     = a[COORD_BITS-1:0];
		end
	end

	// One midpoint decision per step.
	logic shallow, up, diag;

	always_comb begin
		shallow = (oct_q == mlr_pkg::OCT_SHALLOW_UP) || (oct_q == mlr_pkg::OCT_SHALLOW_DOWN);
		up      = (oct_q == mlr_pkg::OCT_SHALLOW_UP) || (oct_q == mlr_pkg::OCT_STEEP_UP);
		case (oct_q)
			mlr_pkg::OCT_SHALLOW_UP:   diag = d_q <= 0;
			mlr_pkg::OCT_SHALLOW_DOWN: diag = d_q > 0;
			mlr_pkg::OCT_STEEP_UP:     diag = d_q > 0;
			mlr_pkg::OCT_STEEP_DOWN:   diag = d_q <= 0;
			default:                   diag = 1'b0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			x_q     <= x0;
			y_q     <= y0;
			n_q     <= n_init;
			d_q     <= d_init;
			inc_s_q <= inc_s_init;
			inc_d_q <= inc_d_init;
			oct_q   <= oct_init;
		end else if (cmd.step) begin
			d_q <= d_q + (diag ? inc_d_q : inc_s_q);
			n_q <= n_q - COORD_BITS'(1);
			if (shallow || diag) begin
				x_q <= x_q + COORD_BITS'(1);
			end
			if (!shallow || diag) begin
				y_q <= up ? y_q + COORD_BITS'(1) : y_q - COORD_BITS'(1);
			end
		end
	end

	assign sts.last   = n_q == '0;
	assign pixel_x    = x_q;
	assign pixel_y    = y_q;
	assign last_pixel = sts.last;

endmodule

FILE: design/midpoint_line_rasterizer.sv
// Midpoint line rasterizer: takes one segment word (two endpoints) and emits every pixel of
// the line, one pixel word per cycle while the output is taken, with last_pixel set on the
// final one. Endpoints are ordered left to right; a vertical segment runs from start toward
// end. A segment yields max(|dx|, |dy|) + 1 pixels, stepped by the single decision adder;
// the next segment is accepted in the same cycle that the previous segment's last pixel is
// taken, so there is no gap.
module midpoint_line_rasterizer #(
	parameter int COORD_BITS = 6
) (
	input  logic   clk,
	input  logic   arst_n,
	mlr_seg_if.sink   seg,
	mlr_pix_if.source pix
);

	mlr_pkg::cmd_t cmd;
	mlr_pkg::sts_t sts;

	mlr_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.seg_valid (seg.valid),
		.seg_ready (seg.ready),
		.pix_valid (pix.valid),
		.pix_ready (pix.ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	mlr_dp #(
		.COORD_BITS (COORD_BITS)
	) u_dp (
		.clk        (clk),
		.cmd        (cmd),
		.sts        (sts),
		.start_x    (seg.start_x),
		.start_y    (seg.start_y),
		.end_x      (seg.end_x),
		.end_y      (seg.end_y),
		.pixel_x    (pix.pixel_x),
		.pixel_y    (pix.pixel_y),
		.last_pixel (pix.last_pixel)
	);

endmodule

FILE: sim/mlr_pixel_checker.sv
module mlr_pixel_checker #(
	parameter int COORD_BITS = 6
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  seg_valid,
	input  logic                  seg_ready,
	input  logic [COORD_BITS-1:0] start_x,
	input  logic [COORD_BITS-1:0] start_y,
	input  logic [COORD_BITS-1:0] end_x,
	input  logic [COORD_BITS-1:0] end_y,
	input  logic                  pix_valid,
	input  logic                  pix_ready,
	input  logic [COORD_BITS-1:0] pixel_x,
	input  logic [COORD_BITS-1:0] pixel_y,
	input  logic                  last_pixel,
	output int                    mismatches,
	output int                    pixels_outstanding
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int MAX_PIXELS = 1 << COORD_BITS;
	localparam int MAX_PRINTED = 100;

	typedef struct packed {
		logic [COORD_BITS-1:0] x;
		logic [COORD_BITS-1:0] y;
		logic                  last;
	} pixel_word_t;

	pixel_word_t expected_pixels[$];

	initial begin
		mismatches = 0;
		pixels_outstanding = 0;
	end

	task automatic report_mismatch(input string msg);
		mismatches++;
		if (mismatches <= MAX_PRINTED) begin
			$display("%0t ns: mismatch: %s", $realtime, msg);
		end
	endtask

	// Queues every pixel of one segment, the final one flagged as last.
	task automatic rasterize_segment(input logic [COORD_BITS-1:0] sx,
		input logic [COORD_BITS-1:0] sy, input logic [COORD_BITS-1:0] ex,
		input logic [COORD_BITS-1:0] ey);
		int x0, y0, x1, y1, swap, a, b, rise, d, inc_s, inc_d, x, y, k;
		mlr_pkg::octant_t oct;
		pixel_word_t w;
		x0 = sx;
		y0 = sy;
		x1 = ex;
		y1 = ey;
		if (x1 < x0) begin
			swap = x0; x0 = x1; x1 = swap;
			swap = y0; y0 = y1; y1 = swap;
		end
		a = y0 - y1;
		b = x1 - x0;
		rise = -a;
		if (rise >= 0 && rise <= b) begin
			oct = mlr_pkg::OCT_SHALLOW_UP;
			d = 2 * a + b; inc_s = 2 * a; inc_d = 2 * (a + b);
		end else if (rise <= 0 && rise >= -b) begin
			oct = mlr_pkg::OCT_SHALLOW_DOWN;
			d = 2 * a - b; inc_s = 2 * a; inc_d = 2 * a - 2 * b;
		end else if (rise > b) begin
			oct = mlr_pkg::OCT_STEEP_UP;
			d = a + 2 * b; inc_s = 2 * b; inc_d = 2 * (a + b);
		end else begin
			oct = mlr_pkg::OCT_STEEP_DOWN;
			d = a - 2 * b; inc_s = -2 * b; inc_d = 2 * (a - b);
		end
		x = x0;
		y = y0;
		k = 1;
		w.x = x[COORD_BITS-1:0];
		w.y = y[COORD_BITS-1:0];
		w.last = 1'b0;
		while (k < MAX_PIXELS && (oct == mlr_pkg::OCT_STEEP_UP ? y < y1 :
			oct == mlr_pkg::OCT_STEEP_DOWN ? y > y1 : x < x1)) begin
			expected_pixels.push_back(w);
			// A decision value of zero goes diagonal in the rising shallow and
			// falling steep octants, straight in the other two.
			case (oct)
				mlr_pkg::OCT_SHALLOW_UP: begin
					x++;
					if (d <= 0) begin
						y++;
						d += inc_d;
					end else begin
						d += inc_s;
					end
				end
				mlr_pkg::OCT_SHALLOW_DOWN: begin
					x++;
					if (d > 0) begin
						y--;
						d += inc_d;
					end else begin
						d += inc_s;
					end
				end
				mlr_pkg::OCT_STEEP_UP: begin
					y++;
					if (d > 0) begin
						x++;
						d += inc_d;
					end else begin
						d += inc_s;
					end
				end
				default: begin
					y--;
					if (d <= 0) begin
						x++;
						d += inc_d;
					end else begin
						d += inc_s;
					end
				end
			endcase
			w.x = x[COORD_BITS-1:0];
			w.y = y[COORD_BITS-1:0];
			k++;
		end
		w.last = 1'b1;
		expected_pixels.push_back(w);
	endtask

	always @(posedge clk) begin
		pixel_word_t want;
		if (arst_n) begin
			if (pix_valid && pix_ready) begin
				if (expected_pixels.size() == 0) begin
					report_mismatch($sformatf("unexpected pixel (%0d,%0d) last=%0d",
						pixel_x, pixel_y, last_pixel));
				end else begin
					want = expected_pixels.pop_front();
					if (pixel_x !== want.x) begin
						report_mismatch($sformatf("pixel_x %0d, expected %0d",
							pixel_x, want.x));
					end
					if (pixel_y !== want.y) begin
						report_mismatch($sformatf("pixel_y %0d, expected %0d",
							pixel_y, want.y));
					end
					if (last_pixel !== want.last) begin
						report_mismatch($sformatf("last_pixel %0d, expected %0d at (%0d,%0d)",
							last_pixel, want.last, want.x, want.y));
					end
				end
			end
			if (seg_valid && seg_ready) begin
				rasterize_segment(start_x, start_y, end_x, end_y);
			end
			pixels_outstanding <= expected_pixels.size();
		end
	end

endmodule

FILE: sim/midpoint_line_rasterizer_tb.sv
module midpoint_line_rasterizer_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int COORD_BITS = 6;
	localparam int CYCLE_LIMIT = 400000;
	localparam int DRAIN_CYCLES = 80;
	localparam int RANDOM_PER_PHASE = 118;
	localparam int MAX_COORD = (1 << COORD_BITS) - 1;

	logic clk = 1'b0;
	logic arst_n;
	logic pix_take = 1'b0;
	int send_idle_pct = 18;
	int recv_idle_pct = 51;
	int cycle_count = 0;
	int mismatches;
	int pixels_outstanding;

	mlr_seg_if #(.COORD_BITS(COORD_BITS)) seg_bus ();
	mlr_pix_if #(.COORD_BITS(COORD_BITS)) pix_bus ();

	midpoint_line_rasterizer #(.COORD_BITS(COORD_BITS)) uut (
		.clk    (clk),
		.arst_n (arst_n),
		.seg    (seg_bus),
		.pix    (pix_bus)
	);

	mlr_pixel_checker #(.COORD_BITS(COORD_BITS)) pixel_checker (
		.clk                (clk),
		.arst_n             (arst_n),
		.seg_valid          (seg_bus.valid),
		.seg_ready          (seg_bus.ready),
		.start_x            (seg_bus.start_x),
		.start_y            (seg_bus.start_y),
		.end_x              (seg_bus.end_x),
		.end_y              (seg_bus.end_y),
		.pix_valid          (pix_bus.valid),
		.pix_ready          (pix_bus.ready),
		.pixel_x            (pix_bus.pixel_x),
		.pixel_y            (pix_bus.pixel_y),
		.last_pixel         (pix_bus.last_pixel),
		.mismatches         (mismatches),
		.pixels_outstanding (pixels_outstanding)
	);

	assign pix_bus.ready = pix_take;

	initial begin
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		pix_take <= (int'($urandom_range(0, 99)) >= recv_idle_pct);
	end

	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("[midpoint_line_rasterizer] ERROR");
		$finish;
	end

	function automatic logic [COORD_BITS-1:0] clip(input int v);
		if (v < 0) begin
			return '0;
		end else if (v > MAX_COORD) begin
			return COORD_BITS'(MAX_COORD);
		end
		return COORD_BITS'(v);
	endfunction

	// Holds the segment word until it is taken; valid stays up across back-to-back words.
	task automatic send_segment(input int sx, input int sy, input int ex, input int ey);
		while (int'($urandom_range(0, 99)) < send_idle_pct) begin
			seg_bus.valid <= 1'b0;
			@(posedge clk);
		end
		seg_bus.valid   <= 1'b1;
		seg_bus.start_x <= COORD_BITS'(sx);
		seg_bus.start_y <= COORD_BITS'(sy);
		seg_bus.end_x   <= COORD_BITS'(ex);
		seg_bus.end_y   <= COORD_BITS'(ey);
		do begin
			@(posedge clk);
		end while (!seg_bus.ready);
	endtask

	task automatic send_random_segment();
		int sx, sy, ex, ey, len, kind, dir;
		kind = $urandom_range(0, 99);
		sx = $urandom_range(0, MAX_COORD);
		sy = $urandom_range(0, MAX_COORD);
		ex = $urandom_range(0, MAX_COORD);
		ey = $urandom_range(0, MAX_COORD);
		if (kind < 50) begin
			// full-range endpoints as drawn
		end else if (kind < 72) begin
			ex = clip(sx + int'($urandom_range(0, 10)) - 5);
			ey = clip(sy + int'($urandom_range(0, 10)) - 5);
		end else if (kind < 78) begin
			ey = sy;
		end else if (kind < 84) begin
			ex = sx;
		end else if (kind < 90) begin
			len = $urandom_range(0, MAX_COORD);
			sx = $urandom_range(0, MAX_COORD - len);
			ex = sx + len;
			sy = $urandom_range(0, MAX_COORD - len);
			ey = sy + len;
			if ($urandom_range(0, 1)) begin
				sy = MAX_COORD - sy;
				ey = MAX_COORD - ey;
			end
			if ($urandom_range(0, 1)) begin
				len = sx; sx = ex; ex = len;
				len = sy; sy = ey; ey = len;
			end
		end else if (kind < 94) begin
			ex = sx;
			ey = sy;
		end else begin
			// One axis twice the other: the first decision value is exactly zero.
			len = $urandom_range(1, MAX_COORD / 2);
			dir = $urandom_range(0, 3);
			sx = $urandom_range(0, MAX_COORD - 2 * len);
			sy = $urandom_range(0, MAX_COORD - 2 * len);
			ex = sx + ((dir < 2) ? 2 * len : len);
			ey = sy + ((dir < 2) ? len : 2 * len);
			if (dir[0]) begin
				len = sy; sy = ey; ey = len;
			end
		end
		send_segment(sx, sy, ex, ey);
	endtask

	initial begin
		arst_n          <= 1'b0;
		seg_bus.valid   <= 1'b0;
		seg_bus.start_x <= '0;
		seg_bus.start_y <= '0;
		seg_bus.end_x   <= '0;
		seg_bus.end_y   <= '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Zero length, axis lines both ways, diagonals, every octant and the tie cases.
		send_segment(0, 0, 0, 0);
		send_segment(63, 63, 63, 63);
		send_segment(0, 0, 63, 0);
		send_segment(63, 42, 0, 42);
		send_segment(10, 0, 10, 63);
		send_segment(21, 63, 21, 0);
		send_segment(0, 0, 63, 63);
		send_segment(0, 63, 63, 0);
		send_segment(63, 63, 0, 0);
		send_segment(63, 0, 0, 63);
		send_segment(0, 0, 63, 20);
		send_segment(0, 40, 63, 3);
		send_segment(3, 0, 20, 63);
		send_segment(5, 63, 30, 0);
		send_segment(50, 60, 2, 1);
		send_segment(0, 0, 4, 2);
		send_segment(0, 2, 4, 0);
		send_segment(0, 0, 2, 4);
		send_segment(0, 4, 2, 0);
		send_segment(5, 5, 6, 5);
		send_segment(5, 5, 5, 4);
		send_segment(42, 21, 21, 42);

		for (int phase = 0; phase < 3; phase++) begin
			if (phase == 1) begin
				send_idle_pct = 51;
				recv_idle_pct = 18;
			end else if (phase == 2) begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end
			for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
				send_random_segment();
			end
		end
		seg_bus.valid <= 1'b0;

		@(posedge clk);
		while (pixels_outstanding != 0) begin
			@(posedge clk);
		end
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (mismatches == 0 && pixels_outstanding == 0) begin
			$display("[midpoint_line_rasterizer] OK");
		end else begin
			$display("[midpoint_line_rasterizer] ERROR");
		end
		$finish;
	end

endmodule

FILE: files.f
design/mlr_pkg.sv
design/mlr_seg_if.sv
design/mlr_pix_if.sv
design/mlr_ctrl.sv
design/mlr_dp.sv
design/midpoint_line_rasterizer.sv
sim/mlr_pixel_checker.sv
sim/midpoint_line_rasterizer_tb.sv
